// File: design/serial_frame_receiver_defines.svh
// Assertion macros used by the serial frame receiver top level.
`ifndef SERIAL_FRAME_RECEIVER_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked at every rising clk edge outside reset.
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("serial_frame_receiver: same-cycle check failed");

// Next-cycle implication, checked at every rising clk edge outside reset.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("serial_frame_receiver: next-cycle check failed");

`endif

// File: design/sfr_pkg.sv
// Shared types and constants of the serial frame receiver.
package sfr_pkg;

    localparam int INDEX_BITS   = 11;
    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 16;
    localparam int SUM_W        = 16;
    localparam int BODY_INDEX_W = 11;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;

    // Largest body count the index counter can hold.
    localparam logic [LEN_W-1:0] COUNT_CAP = LEN_W'((1 << INDEX_BITS) - 1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_FIRST  = 3'd0,
        CFG_START_SECOND = 3'd1,
        CFG_END_BYTE     = 3'd2,
        CFG_MIN_LEN      = 3'd3,
        CFG_MAX_LEN      = 3'd4,
        CFG_TRAILER_LEN  = 3'd5
    } sfr_cfg_index_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_LEN  = 2'd1,
        ST_CSUM = 2'd2,
        ST_ENDD = 2'd3
    } sfr_status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_first;
        logic [BYTE_W-1:0] start_second;
        logic [BYTE_W-1:0] end_byte;
        logic [LEN_W-1:0]  min_len;
        logic [LEN_W-1:0]  max_len;
        logic [LEN_W-1:0]  trailer_len;
    } sfr_cfg_t;

    typedef struct packed {
        logic                    body_valid;
        logic [BYTE_W-1:0]       body_byte;
        logic [BODY_INDEX_W-1:0] body_index;
        logic                    frame_done;
        sfr_status_t             frame_status;
    } sfr_result_t;

    // Input register contents handed to the parser.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] rx_byte;
    } sfr_held_t;

endpackage

// File: design/sfr_if.sv
// Stream interfaces: received bytes in, frame results out.
interface sfr_in_if;
    import sfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_out_if;
    import sfr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    body_valid;
    logic [BYTE_W-1:0]       body_byte;
    logic [BODY_INDEX_W-1:0] body_index;
    logic                    frame_done;
    logic [1:0]              frame_status;

    modport source (output valid, output body_valid, output body_byte, output body_index,
                    output frame_done, output frame_status, input ready);
    modport sink   (input valid, input body_valid, input body_byte, input body_index,
                    input frame_done, input frame_status, output ready);
endinterface

// File: design/sfr_cfg_regs.sv
// Configuration register file with plain write port.
module sfr_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output sfr_pkg::sfr_cfg_t               cfg
);
    import sfr_pkg::*;

    sfr_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_first  <= 8'hAA;
            cfg_reg.start_second <= 8'h55;
            cfg_reg.end_byte     <= 8'h0D;
            cfg_reg.min_len      <= 16'd4;
            cfg_reg.max_len      <= 16'd1036;
            cfg_reg.trailer_len  <= 16'd3;
        end
        else if (cfg_we)
        begin
            unique case (sfr_cfg_index_t'(cfg_index))
                CFG_START_FIRST:  cfg_reg.start_first  <= cfg_data[BYTE_W-1:0];
                CFG_START_SECOND: cfg_reg.start_second <= cfg_data[BYTE_W-1:0];
                CFG_END_BYTE:     cfg_reg.end_byte     <= cfg_data[BYTE_W-1:0];
                CFG_MIN_LEN:      cfg_reg.min_len      <= cfg_data[LEN_W-1:0];
                CFG_MAX_LEN:      cfg_reg.max_len      <= cfg_data[LEN_W-1:0];
                CFG_TRAILER_LEN:  cfg_reg.trailer_len  <= cfg_data[LEN_W-1:0];
                default:          ;  // unmapped index: write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

// File: design/sfr_in_stage.sv
// Input register: holds one received byte until the parser consumes it.
module sfr_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    sfr_in_if.sink             rx,
    input  logic               fire,
    output sfr_pkg::sfr_held_t held
);
    import sfr_pkg::*;

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              take;

    // Refill in the same cycle the held byte moves on.
    assign rx.ready = !valid_reg || fire;
    assign take     = rx.valid && rx.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

    assign held.valid   = valid_reg;
    assign held.rx_byte = byte_reg;
endmodule

// File: design/sfr_parser.sv
// Frame parser: phase machine, running checksum, length and body counter.
module sfr_parser (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  logic [sfr_pkg::BYTE_W-1:0] rx_byte,
    input  sfr_pkg::sfr_cfg_t         cfg,
    output sfr_pkg::sfr_result_t      result
);
    import sfr_pkg::*;

    typedef enum logic [7:0] {
        PH_SD0  = 8'b0000_0001,
        PH_SD1  = 8'b0000_0010,
        PH_LEN0 = 8'b0000_0100,
        PH_LEN1 = 8'b0000_1000,
        PH_BODY = 8'b0001_0000,
        PH_CS0  = 8'b0010_0000,
        PH_CS1  = 8'b0100_0000,
        PH_END  = 8'b1000_0000
    } sfr_phase_t;

    sfr_phase_t              phase_reg, phase_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [INDEX_BITS-1:0]   count_reg, count_next;

    logic [SUM_W-1:0]        sum_add;
    logic [LEN_W-1:0]        len_full;
    logic [LEN_W-1:0]        limit;
    logic [LEN_W-1:0]        count_ext;
    logic [LEN_W-1:0]        count_new_ext;
    logic                    store;
    logic                    body_finished;

    assign sum_add   = sum_reg + SUM_W'(rx_byte);
    assign len_full  = {rx_byte, len_reg[BYTE_W-1:0]};
    assign limit     = (cfg.max_len < COUNT_CAP) ? cfg.max_len : COUNT_CAP;
    assign count_ext = LEN_W'(count_reg);
    assign store     = count_ext < limit;
    assign count_new_ext = store ? count_ext + LEN_W'(1) : count_ext;

    // Body done once length minus trailer bytes are counted or the store
    // limit is reached; a length not above the trailer still takes one body byte.
    assign body_finished = (len_reg <= cfg.trailer_len) ||
                           ((len_reg - cfg.trailer_len) <= count_new_ext) ||
                           (count_new_ext >= limit);

    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        len_next   = len_reg;
        count_next = count_reg;
        result     = '0;

        unique case (phase_reg)
            PH_SD0:
            begin
                if (rx_byte == cfg.start_first)
                begin
                    phase_next = PH_SD1;
                    sum_next   = SUM_W'(rx_byte);
                    count_next = '0;
                end
            end
            PH_SD1:
            begin
                if (rx_byte == cfg.start_second)
                begin
                    phase_next = PH_LEN0;
                    sum_next   = sum_add;
                end
                else
                begin
                    phase_next = PH_SD0;
                end
            end
            PH_LEN0:
            begin
                len_next   = LEN_W'(rx_byte);
                sum_next   = sum_add;
                phase_next = PH_LEN1;
            end
            PH_LEN1:
            begin
                len_next = len_full;
                if ((len_full < cfg.min_len) || (len_full > cfg.max_len))
                begin
                    phase_next          = PH_SD0;
                    result.frame_done   = 1'b1;
                    result.frame_status = ST_LEN;
                end
                else
                begin
                    sum_next   = sum_add;
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (store)
                begin
                    result.body_valid = 1'b1;
                    result.body_byte  = rx_byte;
                    result.body_index = BODY_INDEX_W'(count_reg);
                    count_next        = INDEX_BITS'(count_new_ext);
                end
                sum_next = sum_add;
                if (body_finished)
                begin
                    phase_next = PH_CS0;
                end
            end
            PH_CS0:
            begin
                if (sum_reg[7:0] == rx_byte)
                begin
                    phase_next = PH_CS1;
                end
                else
                begin
                    phase_next          = PH_SD0;
                    result.frame_done   = 1'b1;
                    result.frame_status = ST_CSUM;
                end
            end
            PH_CS1:
            begin
                if (sum_reg[15:8] == rx_byte)
                begin
                    phase_next = PH_END;
                end
                else
                begin
                    phase_next          = PH_SD0;
                    result.frame_done   = 1'b1;
                    result.frame_status = ST_CSUM;
                end
            end
            PH_END:
            begin
                phase_next          = PH_SD0;
                result.frame_done   = 1'b1;
                result.frame_status = (rx_byte == cfg.end_byte) ? ST_OK : ST_ENDD;
            end
            default:
            begin
                phase_next = PH_SD0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SD0;
            sum_reg   <= '0;
            len_reg   <= '0;
            count_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            len_reg   <= len_next;
            count_reg <= count_next;
        end
    end
endmodule

// File: design/sfr_out_stage.sv
// Result register feeding the output channel.
module sfr_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  sfr_pkg::sfr_result_t result,
    output logic                 can_load,
    sfr_out_if.source            res
);
    import sfr_pkg::*;

    logic        valid_reg;
    sfr_result_t data_reg;

    assign can_load = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg <= result;
        end
    end

    assign res.valid        = valid_reg;
    assign res.body_valid   = data_reg.body_valid;
    assign res.body_byte    = data_reg.body_byte;
    assign res.body_index   = data_reg.body_index;
    assign res.frame_done   = data_reg.frame_done;
    assign res.frame_status = data_reg.frame_status;
endmodule

// File: design/serial_frame_receiver.sv
// Top level of the serial frame receiver.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+----------------------------------------------
//  rx       | in  | valid / ready   | rx_byte
//  result   | out | valid / ready   | body_valid body_byte body_index frame_done
//           |     |                 | frame_status
//  cfg      | in  | cfg_we only     | cfg_index cfg_data (write only)
//
// Every byte transfer on rx yields exactly one result transfer: rx_byte
// lands in the input register, then the parser decodes it into the result
// register. One byte per cycle sustained while result does not stall; the
// parser updates phase, 16-bit sum, length and body counter for each byte
// as it moves from the input register to the result register.
// Reset (rst_n low, async) empties both registers, returns to hunting for
// the first start byte and loads the default delimiters and limits.
// A stall on result holds the result register; the input register still
// takes a byte if it is empty, then rx.ready drops until result drains.

`include "serial_frame_receiver_defines.svh"

module serial_frame_receiver (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    sfr_in_if.sink                          rx,
    sfr_out_if.source                       result
);
    import sfr_pkg::*;

    sfr_cfg_t    cfg;
    sfr_held_t   held;
    sfr_result_t parsed;
    logic        can_load;
    logic        fire;

    // A held byte moves through the parser whenever the result slot frees.
    assign fire = held.valid && can_load;

    sfr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfr_in_stage u_in (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .fire  (fire),
        .held  (held)
    );

    sfr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (held.rx_byte),
        .cfg     (cfg),
        .result  (parsed)
    );

    sfr_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .result   (parsed),
        .can_load (can_load),
        .res      (result)
    );

    // A body byte never closes a frame in the same result.
    `SFR_ASSERT_NOW(a_body_not_done, clk, rst_n,
        result.valid && result.body_valid, !result.frame_done)
    // rx backpressure only while a byte is held.
    `SFR_ASSERT_NOW(a_ready_means_room, clk, rst_n, !rx.ready, held.valid)
    // A stalled result slot blocks the parser.
    `SFR_ASSERT_NOW(a_no_fire_on_stall, clk, rst_n,
        result.valid && !result.ready, !fire)
    // A parser step always leaves a result behind.
    `SFR_ASSERT_NEXT(a_fire_fills_out, clk, rst_n, fire, result.valid)
endmodule

// File: bench/serial_frame_receiver_checker.sv
// Checker for the serial frame receiver: tracks frames in the rx byte stream and compares results.
`timescale 1ns / 1ps

module serial_frame_receiver_checker
    import sfr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    rx_valid,
    input  logic                    rx_ready,
    input  logic [BYTE_W-1:0]       rx_byte,
    input  logic                    res_valid,
    input  logic                    res_ready,
    input  logic                    body_valid,
    input  logic [BYTE_W-1:0]       body_byte,
    input  logic [BODY_INDEX_W-1:0] body_index,
    input  logic                    frame_done,
    input  logic [1:0]              frame_status,
    output int                      pending,
    output int                      errors
);

    localparam int MAX_REPORTS = 40;

    localparam sfr_cfg_t RESET_SETTINGS = '{start_first: 8'hAA, start_second: 8'h55,
                                            end_byte: 8'h0D, min_len: 16'd4,
                                            max_len: 16'd1036, trailer_len: 16'd3};

    typedef enum logic [2:0] {
        PH_HUNT_FIRST,
        PH_HUNT_SECOND,
        PH_LEN_LOW,
        PH_LEN_HIGH,
        PH_BODY,
        PH_SUM_LOW,
        PH_SUM_HIGH,
        PH_END_DELIM
    } parse_phase_t;

    sfr_cfg_t               settings;
    parse_phase_t           phase;
    logic [SUM_W-1:0]       frame_sum;
    logic [LEN_W-1:0]       frame_len;
    logic [INDEX_BITS-1:0]  stored_count;
    sfr_result_t            decoded_q[$];

    task automatic report_mismatch(input string msg);
        if (errors < MAX_REPORTS)
            $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    // Advances the frame tracker by one received byte.
    function automatic sfr_result_t decode_rx_byte(input logic [BYTE_W-1:0] b);
        sfr_result_t     r;
        logic [LEN_W-1:0] limit;
        logic            finished;
        r = '0;
        r.frame_status = ST_OK;
        case (phase)
            PH_HUNT_FIRST:
                if (b == settings.start_first)
                begin
                    phase        = PH_HUNT_SECOND;
                    frame_sum    = SUM_W'(b);
                    stored_count = '0;
                end
            PH_HUNT_SECOND:
                if (b == settings.start_second)
                begin
                    phase     = PH_LEN_LOW;
                    frame_sum = frame_sum + SUM_W'(b);
                end
                else
                    phase = PH_HUNT_FIRST;
            PH_LEN_LOW:
            begin
                frame_len = LEN_W'(b);
                frame_sum = frame_sum + SUM_W'(b);
                phase     = PH_LEN_HIGH;
            end
            PH_LEN_HIGH:
            begin
                frame_len[15:8] = b;
                if (frame_len < settings.min_len || frame_len > settings.max_len)
                begin
                    phase          = PH_HUNT_FIRST;
                    r.frame_done   = 1'b1;
                    r.frame_status = ST_LEN;
                end
                else
                begin
                    frame_sum = frame_sum + SUM_W'(b);
                    phase     = PH_BODY;
                end
            end
            PH_BODY:
            begin
                limit = (settings.max_len < COUNT_CAP) ? settings.max_len : COUNT_CAP;
                if (LEN_W'(stored_count) < limit)
                begin
                    r.body_valid = 1'b1;
                    r.body_byte  = b;
                    r.body_index = BODY_INDEX_W'(stored_count);
                    stored_count = stored_count + 1'b1;
                end
                // unstored bytes past the limit still count toward the sum
                frame_sum = frame_sum + SUM_W'(b);
                finished  = (frame_len <= settings.trailer_len) ||
                            ((frame_len - settings.trailer_len) <= LEN_W'(stored_count));
                if (finished || LEN_W'(stored_count) >= limit)
                    phase = PH_SUM_LOW;
            end
            PH_SUM_LOW:
                if (frame_sum[7:0] == b)
                    phase = PH_SUM_HIGH;
                else
                begin
                    phase          = PH_HUNT_FIRST;
                    r.frame_done   = 1'b1;
                    r.frame_status = ST_CSUM;
                end
            PH_SUM_HIGH:
                if (frame_sum[15:8] == b)
                    phase = PH_END_DELIM;
                else
                begin
                    phase          = PH_HUNT_FIRST;
                    r.frame_done   = 1'b1;
                    r.frame_status = ST_CSUM;
                end
            default:
            begin
                r.frame_done   = 1'b1;
                r.frame_status = (b == settings.end_byte) ? ST_OK : ST_ENDD;
                phase          = PH_HUNT_FIRST;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sfr_result_t want;
        if (!rst_n)
        begin
            settings     = RESET_SETTINGS;
            phase        = PH_HUNT_FIRST;
            frame_sum    = '0;
            frame_len    = '0;
            stored_count = '0;
            decoded_q.delete();
            pending      = 0;
            errors       = 0;
        end
        else
        begin
            // compare first, so a stray result cannot consume this cycle's prediction
            if (res_valid && res_ready)
            begin
                if (decoded_q.size() == 0)
                    report_mismatch($sformatf("result transfer with nothing outstanding (done %0b)",
                                              frame_done));
                else
                begin
                    want = decoded_q.pop_front();
                    if (body_valid != want.body_valid)
                        report_mismatch($sformatf("body_valid got %0b expected %0b",
                                                  body_valid, want.body_valid));
                    if (body_byte != want.body_byte)
                        report_mismatch($sformatf("body_byte got %02h expected %02h",
                                                  body_byte, want.body_byte));
                    if (body_index != want.body_index)
                        report_mismatch($sformatf("body_index got %0d expected %0d",
                                                  body_index, want.body_index));
                    if (frame_done != want.frame_done)
                        report_mismatch($sformatf("frame_done got %0b expected %0b",
                                                  frame_done, want.frame_done));
                    if (frame_status != want.frame_status)
                        report_mismatch($sformatf("frame_status got %0d expected %0d",
                                                  frame_status, want.frame_status));
                end
            end
            if (cfg_we)
            begin
                case (sfr_cfg_index_t'(cfg_index))
                    CFG_START_FIRST:  settings.start_first  = cfg_data[BYTE_W-1:0];
                    CFG_START_SECOND: settings.start_second = cfg_data[BYTE_W-1:0];
                    CFG_END_BYTE:     settings.end_byte     = cfg_data[BYTE_W-1:0];
                    CFG_MIN_LEN:      settings.min_len      = cfg_data;
                    CFG_MAX_LEN:      settings.max_len      = cfg_data;
                    CFG_TRAILER_LEN:  settings.trailer_len  = cfg_data;
                    default: ;
                endcase
            end
            if (rx_valid && rx_ready)
                decoded_q.push_back(decode_rx_byte(rx_byte));
            pending = decoded_q.size();
        end
    end

endmodule

// File: bench/serial_frame_receiver_tb.sv
// Top of the serial frame receiver bench: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

module serial_frame_receiver_tb;
    import sfr_pkg::*;

    localparam int RESET_CYCLES = 8;
    localparam int IDLE_PCT     = 7;      // chance per cycle that a side idles
    localparam int STALL_LIMIT  = 1000;   // cycles with no transfer before giving up
    localparam int TAIL_CYCLES  = 10;     // drain time after the last result

    localparam sfr_cfg_t RESET_SETTINGS = '{start_first: 8'hAA, start_second: 8'h55,
                                            end_byte: 8'h0D, min_len: 16'd4,
                                            max_len: 16'd1036, trailer_len: 16'd3};

    // How a generated frame is (or is not) damaged.
    typedef enum {
        FRAME_GOOD,
        FRAME_BAD_START,
        FRAME_LEN_LOW,
        FRAME_LEN_HIGH,
        FRAME_BAD_SUM_LO,
        FRAME_BAD_SUM_HI,
        FRAME_BAD_END
    } frame_kind_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    sfr_in_if  rx_ch();
    sfr_out_if res_ch();

    // Stimulus-side copy of the register contents, used to build frames.
    sfr_cfg_t bus_cfg;
    bit       steady;         // when set, neither side idles
    int       pending;
    int       errors;
    int       sent_bytes;
    int       frames;
    int       settings_loaded;
    int       idle_cycles;

    serial_frame_receiver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx_ch),
        .result    (res_ch)
    );

    serial_frame_receiver_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rx_valid     (rx_ch.valid),
        .rx_ready     (rx_ch.ready),
        .rx_byte      (rx_ch.rx_byte),
        .res_valid    (res_ch.valid),
        .res_ready    (res_ch.ready),
        .body_valid   (res_ch.body_valid),
        .body_byte    (res_ch.body_byte),
        .body_index   (res_ch.body_index),
        .frame_done   (res_ch.frame_done),
        .frame_status (res_ch.frame_status),
        .pending      (pending),
        .errors       (errors)
    );

    always #2 clk = ~clk;

    // Result side: back-pressure at random, unless in the steady stretch.
    always @(negedge clk)
        res_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    // Watchdog: ends the run if neither channel moves for too long.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: %0d cycles without a transfer, %0d results outstanding",
                 idle_cycles, pending);
        $display("== FAIL ==");
        $finish;
    end

    // One byte transfer on rx. Entered and left at a falling edge; may idle
    // first, and valid stays high across back-to-back transfers.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            rx_ch.valid <= 1'b0;
            @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        sent_bytes++;
        @(negedge clk);
    endtask

    // Sends one frame built from the current settings, damaged as kind says.
    // Bytes after the point of rejection are not sent.
    task automatic send_frame(input frame_kind_t kind, input logic [LEN_W-1:0] len,
                              input bit all_ones);
        logic [SUM_W-1:0]  sum;
        logic [LEN_W-1:0]  cap;
        int unsigned       nbody;
        logic [BYTE_W-1:0] b;
        frames++;
        send_byte(bus_cfg.start_first);
        if (kind == FRAME_BAD_START)
        begin
            // any other second byte drops the receiver back to hunting
            send_byte(bus_cfg.start_second ^ BYTE_W'($urandom_range(1, 255)));
            return;
        end
        send_byte(bus_cfg.start_second);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        if (kind == FRAME_LEN_LOW || kind == FRAME_LEN_HIGH)
            return;
        sum = SUM_W'(bus_cfg.start_first) + SUM_W'(bus_cfg.start_second) +
              SUM_W'(len[7:0]) + SUM_W'(len[15:8]);
        // Body size as the receiver counts it: one byte when the length does not
        // exceed the trailer or capacity is zero, else length minus trailer, capped.
        cap = (bus_cfg.max_len < COUNT_CAP) ? bus_cfg.max_len : COUNT_CAP;
        if (len <= bus_cfg.trailer_len || cap == '0)
            nbody = 1;
        else if ((len - bus_cfg.trailer_len) < cap)
            nbody = len - bus_cfg.trailer_len;
        else
            nbody = cap;
        repeat (nbody)
        begin
            b = all_ones ? 8'hFF : BYTE_W'($urandom);
            sum += SUM_W'(b);
            send_byte(b);
        end
        b = sum[7:0];
        if (kind == FRAME_BAD_SUM_LO)
            b ^= BYTE_W'($urandom_range(1, 255));
        send_byte(b);
        if (kind == FRAME_BAD_SUM_LO)
            return;
        b = sum[15:8];
        if (kind == FRAME_BAD_SUM_HI)
            b ^= BYTE_W'($urandom_range(1, 255));
        send_byte(b);
        if (kind == FRAME_BAD_SUM_HI)
            return;
        b = bus_cfg.end_byte;
        if (kind == FRAME_BAD_END)
            b ^= BYTE_W'($urandom_range(1, 255));
        send_byte(b);
    endtask

    // Mostly well-formed frames (none if min_len > max_len), random content, some
    // noise between frames, and a share of each kind of damage the limits allow.
    task automatic random_frame();
        frame_kind_t       kind;
        int unsigned       roll;
        int unsigned       span;
        int unsigned       reach;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] b;
        if ($urandom_range(0, 99) < 15)
        begin
            repeat ($urandom_range(1, 3))
            begin
                b = BYTE_W'($urandom);
                // noise rarely looks like a start byte
                if (b == bus_cfg.start_first && $urandom_range(0, 9) != 0)
                    b = ~b;
                send_byte(b);
            end
        end
        roll = $urandom_range(0, 99);
        if (bus_cfg.min_len > bus_cfg.max_len)
            kind = (roll < 10) ? FRAME_BAD_START : (roll < 55) ? FRAME_LEN_LOW : FRAME_LEN_HIGH;
        else if (roll < 70)
            kind = FRAME_GOOD;
        else if (roll < 75)
            kind = FRAME_BAD_START;
        else if (roll < 80)
            kind = FRAME_LEN_LOW;
        else if (roll < 85)
            kind = FRAME_LEN_HIGH;
        else if (roll < 90)
            kind = FRAME_BAD_SUM_LO;
        else if (roll < 95)
            kind = FRAME_BAD_SUM_HI;
        else
            kind = FRAME_BAD_END;
        if (kind == FRAME_LEN_LOW && bus_cfg.min_len == '0)
            kind = FRAME_GOOD;
        if (kind == FRAME_LEN_HIGH && bus_cfg.max_len == '1)
            kind = FRAME_GOOD;

        case (kind)
            FRAME_LEN_LOW:  len = LEN_W'($urandom_range(0, bus_cfg.min_len - 1));
            FRAME_LEN_HIGH: len = LEN_W'($urandom_range(bus_cfg.max_len + 1, 16'hFFFF));
            default:
            begin
                // small bodies nearly always; a longer one now and then
                span  = bus_cfg.max_len - bus_cfg.min_len;
                reach = ($urandom_range(0, 99) == 0) ? 300 : 24;
                len   = bus_cfg.min_len + LEN_W'($urandom_range(0, (span < reach) ? span : reach));
            end
        endcase
        send_frame(kind, len, 1'b0);
    endtask

    task automatic random_bytes(input int count);
        int target;
        target = sent_bytes + count;
        while (sent_bytes < target)
            random_frame();
    endtask

    // Stops the sender and waits until every result has come back.
    task automatic drain();
        rx_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Writes all six registers in index order; only called while idle.
    task automatic load_settings(input sfr_cfg_t c);
        sfr_cfg_index_t       idx;
        logic [CFG_DATA_W-1:0] val;
        bus_cfg = c;
        settings_loaded++;
        idx = idx.first();
        do
        begin
            case (idx)
                // upper data bits are don't-care for the byte registers
                CFG_START_FIRST:  val = {8'($urandom), c.start_first};
                CFG_START_SECOND: val = {8'($urandom), c.start_second};
                CFG_END_BYTE:     val = {8'($urandom), c.end_byte};
                CFG_MIN_LEN:      val = c.min_len;
                CFG_MAX_LEN:      val = c.max_len;
                default:          val = c.trailer_len;
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(negedge clk);
            idx = idx.next();
        end
        while (idx != idx.first());
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        sfr_cfg_t shuffled;
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        rx_ch.valid     = 1'b0;
        rx_ch.rx_byte   = '0;
        res_ch.ready    = 1'b0;
        steady          = 1'b0;
        sent_bytes      = 0;
        frames          = 0;
        settings_loaded = 1;
        bus_cfg         = RESET_SETTINGS;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, power-on settings: noise bytes at both extremes, a
        // minimal good frame with an all-ones body, a bad second start byte,
        // lengths below and above the limits, and a low checksum byte wrong.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(FRAME_GOOD, 16'd4, 1'b1);
        send_frame(FRAME_BAD_START, 16'd0, 1'b0);
        send_frame(FRAME_LEN_LOW, 16'd3, 1'b0);
        send_frame(FRAME_LEN_HIGH, 16'hFFFF, 1'b0);
        send_frame(FRAME_BAD_SUM_LO, 16'd4, 1'b0);
        random_bytes(200);

        // Widest limits, no trailer, delimiters at the byte extremes. No
        // idling on either side here.
        drain();
        load_settings('{start_first: 8'h00, start_second: 8'hFF, end_byte: 8'hFF,
                        min_len: 16'h0000, max_len: 16'hFFFF, trailer_len: 16'h0000});
        steady = 1'b1;
        random_bytes(150);
        steady = 1'b0;

        // Zero capacity and the largest trailer: only length zero passes, its
        // single body byte is never stored.
        drain();
        load_settings('{start_first: 8'hFF, start_second: 8'h00, end_byte: 8'h00,
                        min_len: 16'h0000, max_len: 16'h0000, trailer_len: 16'hFFFF});
        random_bytes(100);

        // All three delimiters share one value.
        drain();
        load_settings('{start_first: 8'h7E, start_second: 8'h7E, end_byte: 8'h7E,
                        min_len: 16'd1, max_len: 16'd40, trailer_len: 16'd2});
        random_bytes(150);

        drain();
        shuffled.start_first  = BYTE_W'($urandom);
        shuffled.start_second = BYTE_W'($urandom);
        shuffled.end_byte     = BYTE_W'($urandom);
        shuffled.min_len      = LEN_W'($urandom_range(0, 8));
        shuffled.max_len      = LEN_W'($urandom_range(shuffled.min_len, 60));
        shuffled.trailer_len  = LEN_W'($urandom_range(0, 6));
        load_settings(shuffled);
        random_bytes(150);

        // Minimum above maximum: every length is rejected.
        drain();
        load_settings('{start_first: 8'hAA, start_second: 8'h55, end_byte: 8'h0D,
                        min_len: 16'd50, max_len: 16'd10, trailer_len: 16'd3});
        random_bytes(80);

        // Back to the power-on values, written explicitly.
        drain();
        load_settings(RESET_SETTINGS);
        random_bytes(150);

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("covered %0d rx bytes in %0d frames over %0d register settings,",
                 sent_bytes, frames, settings_loaded);
        $display("with length, checksum, end delimiter and body store limit cases");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
